[design/lcw_pkg.sv]
// ----------------------------------------------------------------------------
// lcw_pkg
// Shared types, widths, codes and the microprogram of the load-cell scale.
// ----------------------------------------------------------------------------
`default_nettype none

package lcw_pkg;

  localparam int SampleW  = 24;
  localparam int SumW     = 31;
  localparam int FvW      = 40;
  localparam int DiffW    = 41;
  localparam int AlphaW   = 16;
  localparam int RefW     = 24;
  localparam int NetW     = 25;
  localparam int CpgW     = 48;
  localparam int DivW     = 49;
  localparam int DsrW     = 48;
  localparam int ProdW    = 37;
  localparam int AccW     = 58;
  localparam int WeightW  = 32;
  localparam int CntW     = 7;
  localparam int StepW    = 5;
  localparam int CfgAddrW = 8;
  localparam int CfgDataW = 32;

  localparam logic [CpgW-1:0] CpgReset = 48'd65536;

  localparam logic [CfgAddrW-1:0] REG_FILTER_EN = 8'd0;
  localparam logic [CfgAddrW-1:0] REG_ALPHA     = 8'd1;
  localparam logic [CfgAddrW-1:0] REG_REF       = 8'd2;
  localparam logic [CfgAddrW-1:0] REG_KNOWN     = 8'd3;

  typedef enum logic [1:0] {
    MODE_WEIGH = 2'd0,
    MODE_TARE  = 2'd1,
    MODE_CAL   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_WEIGHT = 2'd0,
    ST_TARE   = 2'd1,
    ST_CAL    = 2'd2,
    ST_REJECT = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIFF,
    OP_MULL,
    OP_MULH,
    OP_PSUM,
    OP_FUPD,
    OP_SUM,
    OP_ADIV,
    OP_ATAKE,
    OP_NET,
    OP_WDIV,
    OP_WSUM,
    OP_WCLAMP,
    OP_WRAW,
    OP_TARE,
    OP_CDIV,
    OP_CTAKE,
    OP_CREJ,
    OP_OUT
  } uop_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOITEM,
    C_NOFILT,
    C_NOTEND,
    C_DIVBUSY,
    C_TARE,
    C_CAL,
    C_NOTARE,
    C_CALBAD,
    C_OUTFULL
  } ucond_e;

  typedef struct packed {
    uop_e               op;
    ucond_e             cond;
    logic [StepW-1:0]   target;
  } uword_t;

  typedef struct packed {
    logic nofilt;
    logic notend;
    logic divbusy;
    logic tare;
    logic cal;
    logic notare;
    logic calbad;
    logic outfull;
  } dp_flags_t;

  // Jump targets of the microprogram
  localparam logic [StepW-1:0] L_FETCH = 5'd0;
  localparam logic [StepW-1:0] L_SUM   = 5'd6;
  localparam logic [StepW-1:0] L_AWAIT = 5'd9;
  localparam logic [StepW-1:0] L_WWAIT = 5'd15;
  localparam logic [StepW-1:0] L_RAW   = 5'd18;
  localparam logic [StepW-1:0] L_TARE  = 5'd19;
  localparam logic [StepW-1:0] L_CAL   = 5'd20;
  localparam logic [StepW-1:0] L_CWAIT = 5'd22;
  localparam logic [StepW-1:0] L_REJ   = 5'd24;
  localparam logic [StepW-1:0] L_OUT   = 5'd25;

  function automatic uword_t ucode(input logic [StepW-1:0] step);
    uword_t w;
    case (step)
      5'd0:    w = '{OP_LOAD,   C_NOITEM,  L_FETCH};
      5'd1:    w = '{OP_DIFF,   C_NOFILT,  L_SUM};
      5'd2:    w = '{OP_MULL,   C_NEVER,   L_FETCH};
      5'd3:    w = '{OP_MULH,   C_NEVER,   L_FETCH};
      5'd4:    w = '{OP_PSUM,   C_NEVER,   L_FETCH};
      5'd5:    w = '{OP_FUPD,   C_NEVER,   L_FETCH};
      5'd6:    w = '{OP_SUM,    C_NEVER,   L_FETCH};
      5'd7:    w = '{OP_NOP,    C_NOTEND,  L_FETCH};
      5'd8:    w = '{OP_ADIV,   C_NEVER,   L_FETCH};
      5'd9:    w = '{OP_NOP,    C_DIVBUSY, L_AWAIT};
      5'd10:   w = '{OP_ATAKE,  C_NEVER,   L_FETCH};
      5'd11:   w = '{OP_NET,    C_TARE,    L_TARE};
      5'd12:   w = '{OP_NOP,    C_CAL,     L_CAL};
      5'd13:   w = '{OP_NOP,    C_NOTARE,  L_RAW};
      5'd14:   w = '{OP_WDIV,   C_NEVER,   L_FETCH};
      5'd15:   w = '{OP_NOP,    C_DIVBUSY, L_WWAIT};
      5'd16:   w = '{OP_WSUM,   C_NEVER,   L_FETCH};
      5'd17:   w = '{OP_WCLAMP, C_ALWAYS,  L_OUT};
      5'd18:   w = '{OP_WRAW,   C_ALWAYS,  L_OUT};
      5'd19:   w = '{OP_TARE,   C_ALWAYS,  L_OUT};
      5'd20:   w = '{OP_NOP,    C_CALBAD,  L_REJ};
      5'd21:   w = '{OP_CDIV,   C_NEVER,   L_FETCH};
      5'd22:   w = '{OP_NOP,    C_DIVBUSY, L_CWAIT};
      5'd23:   w = '{OP_CTAKE,  C_ALWAYS,  L_OUT};
      5'd24:   w = '{OP_CREJ,   C_NEVER,   L_FETCH};
      5'd25:   w = '{OP_OUT,    C_OUTFULL, L_OUT};
      default: w = '{OP_NOP,    C_ALWAYS,  L_FETCH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[design/lcw_div.sv]
// ----------------------------------------------------------------------------
// lcw_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcw_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lcw_pkg::DivW-1:0]  dividend_i,
  input  logic [lcw_pkg::DsrW-1:0]  divisor_i,
  output logic                      busy_o,
  output logic [lcw_pkg::DivW-1:0]  quot_o
);
  import lcw_pkg::*;

  localparam int ItW = $clog2(DivW + 1);
  localparam logic [ItW-1:0] LastIt = ItW'(DivW - 1);

  logic [DsrW-1:0] rem_q, rem_d;
  logic [DivW-1:0] quo_q, quo_d;
  logic [DsrW-1:0] dsr_q, dsr_d;
  logic [ItW-1:0]  it_q, it_d;
  logic            busy_q, busy_d;

  logic [DsrW:0] trial;
  logic          fits;

  assign trial = {rem_q, quo_q[DivW-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    it_d   = it_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
      it_d   = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? DsrW'(trial - {1'b0, dsr_q}) : trial[DsrW-1:0];
      quo_d = {quo_q[DivW-2:0], fits};
      it_d  = it_q + 1'b1;
      if (it_q == LastIt) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      it_q   <= '0;
    end else begin
      busy_q <= busy_d;
      it_q   <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

[design/lcw_seq.sv]
// ----------------------------------------------------------------------------
// lcw_seq
// Microcode sequencer: step counter, program ROM and conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module lcw_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_i,
  input  lcw_pkg::dp_flags_t   flags_i,
  output lcw_pkg::uop_e        op_o,
  output logic                 idle_o
);
  import lcw_pkg::*;

  logic [StepW-1:0] step_q, step_d;
  uword_t           uw;
  logic             take;

  assign uw = ucode(step_q);

  always_comb begin
    unique case (uw.cond)
      C_NEVER:   take = 1'b0;
      C_ALWAYS:  take = 1'b1;
      C_NOITEM:  take = !item_i;
      C_NOFILT:  take = flags_i.nofilt;
      C_NOTEND:  take = flags_i.notend;
      C_DIVBUSY: take = flags_i.divbusy;
      C_TARE:    take = flags_i.tare;
      C_CAL:     take = flags_i.cal;
      C_NOTARE:  take = flags_i.notare;
      C_CALBAD:  take = flags_i.calbad;
      C_OUTFULL: take = flags_i.outfull;
      default:   take = 1'b1;
    endcase
  end

  assign step_d = take ? uw.target : step_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= L_FETCH;
    end else begin
      step_q <= step_d;
    end
  end

  assign op_o   = uw.op;
  assign idle_o = (step_q == L_FETCH);

endmodule

`default_nettype wire

[design/lcw_dp.sv]
// ----------------------------------------------------------------------------
// lcw_dp
// Datapath: filter, window accumulator, tare/scale state and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcw_dp #(
  parameter int WEIGH_WINDOW = 8,
  parameter int TARE_WINDOW  = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lcw_pkg::uop_e                       op_i,
  input  logic                                item_i,
  input  logic signed [lcw_pkg::SampleW-1:0]  sample_i,
  input  logic [1:0]                          mode_i,
  input  logic                                cfg_we_i,
  input  logic [lcw_pkg::CfgAddrW-1:0]        cfg_addr_i,
  input  logic [lcw_pkg::CfgDataW-1:0]        cfg_data_i,
  output logic                                div_start_o,
  output logic [lcw_pkg::DivW-1:0]            div_dividend_o,
  output logic [lcw_pkg::DsrW-1:0]            div_divisor_o,
  input  logic                                div_busy_i,
  input  logic [lcw_pkg::DivW-1:0]            div_quot_i,
  output lcw_pkg::dp_flags_t                  flags_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [lcw_pkg::WeightW-1:0]  weight_o,
  output lcw_pkg::status_e                    status_o,
  output logic                                tared_o,
  output logic                                calibrated_o
);
  import lcw_pkg::*;

  localparam logic [CntW-1:0] WeighLen = CntW'(WEIGH_WINDOW);
  localparam logic [CntW-1:0] TareLen  = CntW'(TARE_WINDOW);

  // Architectural state
  logic                     fen_q, fen_d;
  logic [AlphaW-1:0]        alpha_q, alpha_d;
  logic [RefW-1:0]          ref_q, ref_d;
  logic [RefW-1:0]          known_q, known_d;
  logic signed [FvW-1:0]    fv_q, fv_d;
  logic signed [SumW-1:0]   sum_q, sum_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  mode_e                    wmode_q, wmode_d;
  logic signed [SampleW-1:0] tare_q, tare_d;
  logic [RefW-1:0]          lref_q, lref_d;
  logic [CpgW-1:0]          cpg_q, cpg_d;
  logic                     have_tare_q, have_tare_d;
  logic                     have_scale_q, have_scale_d;
  logic                     out_valid_q, out_valid_d;

  // Scratch and payload
  logic signed [SampleW-1:0] x_q, x_d;
  logic signed [DiffW-1:0]   diff_q, diff_d;
  logic [ProdW-1:0]          pl_q, pl_d;
  logic signed [ProdW-1:0]   ph_q, ph_d;
  logic signed [AccW-1:0]    acc_q, acc_d;
  logic signed [SampleW-1:0] avg_q, avg_d;
  logic signed [NetW-1:0]    net_q, net_d;
  logic signed [NetW-1:0]    kdiff_q, kdiff_d;
  logic                      div_neg_q, div_neg_d;
  logic signed [WeightW-1:0] res_w_q, res_w_d;
  status_e                   res_st_q, res_st_d;
  logic signed [WeightW-1:0] out_w_q, out_w_d;
  status_e                   out_st_q, out_st_d;
  logic                      out_tared_q, out_tared_d;
  logic                      out_cal_q, out_cal_d;

  logic [CntW-1:0]          win_len;
  logic                     acc_rnd, fv_rnd;
  logic signed [DivW:0]     qsign;
  logic [SumW-1:0]          sum_abs;
  logic [NetW-1:0]          net_abs;

  assign win_len = (wmode_q == MODE_WEIGH) ? WeighLen : TareLen;
  assign acc_rnd = acc_q[AccW-1] && (|acc_q[15:0]);
  assign fv_rnd  = fv_q[FvW-1] && (|fv_q[15:0]);
  assign qsign   = div_neg_q ? -$signed({1'b0, div_quot_i}) : $signed({1'b0, div_quot_i});
  assign sum_abs = sum_q[SumW-1] ? SumW'(-sum_q) : sum_q;
  assign net_abs = net_q[NetW-1] ? NetW'(-net_q) : net_q;

  assign div_start_o = (op_i inside {OP_ADIV, OP_WDIV, OP_CDIV});

  always_comb begin
    case (op_i)
      OP_ADIV: begin
        div_dividend_o = {{(DivW-SumW){1'b0}}, sum_abs};
        div_divisor_o  = {{(DsrW-CntW){1'b0}}, win_len};
      end
      OP_WDIV: begin
        div_dividend_o = {1'b0, net_abs[SampleW-1:0], 24'h0};
        div_divisor_o  = cpg_q;
      end
      default: begin
        div_dividend_o = {1'b0, net_q[SampleW-1:0], 24'h0};
        div_divisor_o  = {24'h0, kdiff_q[SampleW-1:0]};
      end
    endcase
  end

  always_comb begin
    flags_o.nofilt  = !fen_q;
    flags_o.notend  = (cnt_q != win_len);
    flags_o.divbusy = div_busy_i;
    flags_o.tare    = (wmode_q == MODE_TARE);
    flags_o.cal     = (wmode_q == MODE_CAL);
    flags_o.notare  = !have_tare_q;
    flags_o.calbad  = !have_tare_q || net_q[NetW-1] || (net_q == '0)
                      || kdiff_q[NetW-1] || (kdiff_q == '0);
    flags_o.outfull = out_valid_q;
  end

  always_comb begin
    fen_d        = fen_q;
    alpha_d      = alpha_q;
    ref_d        = ref_q;
    known_d      = known_q;
    fv_d         = fv_q;
    sum_d        = sum_q;
    cnt_d        = cnt_q;
    wmode_d      = wmode_q;
    tare_d       = tare_q;
    lref_d       = lref_q;
    cpg_d        = cpg_q;
    have_tare_d  = have_tare_q;
    have_scale_d = have_scale_q;
    out_valid_d  = out_valid_q;
    x_d          = x_q;
    diff_d       = diff_q;
    pl_d         = pl_q;
    ph_d         = ph_q;
    acc_d        = acc_q;
    avg_d        = avg_q;
    net_d        = net_q;
    kdiff_d      = kdiff_q;
    div_neg_d    = div_neg_q;
    res_w_d      = res_w_q;
    res_st_d     = res_st_q;
    out_w_d      = out_w_q;
    out_st_d     = out_st_q;
    out_tared_d  = out_tared_q;
    out_cal_d    = out_cal_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (op_i)
      OP_LOAD: begin
        if (item_i) begin
          x_d = sample_i;
          // Mode is taken from the first item of a window only
          if (cnt_q == '0) begin
            case (mode_e'(mode_i))
              MODE_TARE: wmode_d = MODE_TARE;
              MODE_CAL:  wmode_d = MODE_CAL;
              default:   wmode_d = MODE_WEIGH;
            endcase
          end
        end
      end
      OP_DIFF: begin
        diff_d = $signed({x_q[SampleW-1], x_q, 16'h0}) - $signed({fv_q[FvW-1], fv_q});
      end
      OP_MULL: begin
        pl_d = alpha_q * diff_q[20:0];
      end
      OP_MULH: begin
        ph_d = $signed({1'b0, alpha_q}) * $signed(diff_q[DiffW-1:21]);
      end
      OP_PSUM: begin
        acc_d = $signed({ph_q, 21'h0}) + $signed({21'h0, pl_q});
      end
      OP_FUPD: begin
        // Truncate toward zero: floor shift plus one when negative and inexact
        fv_d = fv_q + $signed(acc_q[55:16]) + $signed({{(FvW-1){1'b0}}, acc_rnd});
      end
      OP_SUM: begin
        cnt_d = cnt_q + 1'b1;
        if (fen_q) begin
          sum_d = sum_q + $signed({{(SumW-SampleW){fv_q[FvW-1]}}, fv_q[FvW-1:16]})
                  + $signed({{(SumW-1){1'b0}}, fv_rnd});
        end else begin
          sum_d = sum_q + SumW'(x_q);
        end
      end
      OP_ADIV: begin
        div_neg_d = sum_q[SumW-1];
      end
      OP_ATAKE: begin
        avg_d = qsign[SampleW-1:0];
        sum_d = '0;
        cnt_d = '0;
      end
      OP_NET: begin
        net_d   = NetW'(avg_q) - NetW'(tare_q);
        kdiff_d = $signed({1'b0, known_q}) - $signed({1'b0, lref_q});
      end
      OP_WDIV: begin
        div_neg_d = net_q[NetW-1];
      end
      OP_WSUM: begin
        acc_d = AccW'(qsign) + $signed({{(AccW-RefW){1'b0}}, lref_q});
      end
      OP_WCLAMP: begin
        res_st_d = ST_WEIGHT;
        if (acc_q[AccW-1]) begin
          res_w_d = '0;
        end else if (|acc_q[AccW-2:WeightW-1]) begin
          res_w_d = 32'sh7FFF_FFFF;
        end else begin
          res_w_d = $signed({1'b0, acc_q[WeightW-2:0]});
        end
      end
      OP_WRAW: begin
        res_w_d  = WeightW'(avg_q);
        res_st_d = ST_WEIGHT;
      end
      OP_TARE: begin
        tare_d      = avg_q;
        lref_d      = ref_q;
        have_tare_d = 1'b1;
        res_w_d     = WeightW'(avg_q);
        res_st_d    = ST_TARE;
      end
      OP_CDIV: begin
        div_neg_d = 1'b0;
      end
      OP_CTAKE: begin
        cpg_d        = div_quot_i[CpgW-1:0];
        have_scale_d = 1'b1;
        res_w_d      = '0;
        res_st_d     = ST_CAL;
      end
      OP_CREJ: begin
        res_w_d  = '0;
        res_st_d = ST_REJECT;
      end
      OP_OUT: begin
        if (!out_valid_q) begin
          out_valid_d = 1'b1;
          out_w_d     = res_w_q;
          out_st_d    = res_st_q;
          out_tared_d = have_tare_q;
          out_cal_d   = have_scale_q;
        end
      end
      default: begin
      end
    endcase

    if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_FILTER_EN: begin
          fen_d = cfg_data_i[0];
          fv_d  = '0;
        end
        REG_ALPHA: alpha_d = cfg_data_i[AlphaW-1:0];
        REG_REF:   ref_d   = cfg_data_i[RefW-1:0];
        REG_KNOWN: known_d = cfg_data_i[RefW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fen_q        <= 1'b0;
      alpha_q      <= '0;
      ref_q        <= '0;
      known_q      <= '0;
      fv_q         <= '0;
      sum_q        <= '0;
      cnt_q        <= '0;
      wmode_q      <= MODE_WEIGH;
      tare_q       <= '0;
      lref_q       <= '0;
      cpg_q        <= CpgReset;
      have_tare_q  <= 1'b0;
      have_scale_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      fen_q        <= fen_d;
      alpha_q      <= alpha_d;
      ref_q        <= ref_d;
      known_q      <= known_d;
      fv_q         <= fv_d;
      sum_q        <= sum_d;
      cnt_q        <= cnt_d;
      wmode_q      <= wmode_d;
      tare_q       <= tare_d;
      lref_q       <= lref_d;
      cpg_q        <= cpg_d;
      have_tare_q  <= have_tare_d;
      have_scale_q <= have_scale_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q         <= x_d;
    diff_q      <= diff_d;
    pl_q        <= pl_d;
    ph_q        <= ph_d;
    acc_q       <= acc_d;
    avg_q       <= avg_d;
    net_q       <= net_d;
    kdiff_q     <= kdiff_d;
    div_neg_q   <= div_neg_d;
    res_w_q     <= res_w_d;
    res_st_q    <= res_st_d;
    out_w_q     <= out_w_d;
    out_st_q    <= out_st_d;
    out_tared_q <= out_tared_d;
    out_cal_q   <= out_cal_d;
  end

  assign out_valid_o  = out_valid_q;
  assign weight_o     = out_w_q;
  assign status_o     = out_st_q;
  assign tared_o      = out_tared_q;
  assign calibrated_o = out_cal_q;

endmodule

`default_nettype wire

[design/load_cell_tare_calibrate_weigh.sv]
// Items are taken one at a time. With the filter on, an item runs through 16x21 and 17x20
// multiplies and the filter and window adds; with it off, through the window add alone.
// A window-closing item adds one 49-step divide for the average, and a second one
// for weighing after tare or for a calibration that is not rejected.
// A finished result waits in the output register; the sequencer holds until it is free.
// Reset clears all architectural state at once: no filter, no tare, counts per gram 2^-8 in Q24.
// ----------------------------------------------------------------------------
// load_cell_tare_calibrate_weigh
// Load-cell scale: optional low-pass filter, window averaging, tare, calibrate
// and weigh, run by a microcoded sequencer over a shared iterative divider.
// ----------------------------------------------------------------------------
`default_nettype none

module load_cell_tare_calibrate_weigh #(
  parameter int WEIGH_WINDOW = 8,
  parameter int TARE_WINDOW  = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [23:0]                           s_axis_tdata,   // [23:0] sample
  input  logic [1:0]                            s_axis_tuser,   // [1:0] mode
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [39:0]                           m_axis_tdata,   // [31:0] weight, [32] tared,
                                                                // [33] calibrated, zero pad
  output logic [1:0]                            m_axis_tuser,   // [1:0] status
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [lcw_pkg::CfgAddrW-1:0]          cfg_addr_i,
  input  logic [lcw_pkg::CfgDataW-1:0]          cfg_data_i
);
  import lcw_pkg::*;

  uop_e                      op;
  logic                      idle;
  logic                      item;
  dp_flags_t                 flags;
  logic                      div_start;
  logic [DivW-1:0]           div_dividend;
  logic [DsrW-1:0]           div_divisor;
  logic                      div_busy;
  logic [DivW-1:0]           div_quot;
  logic signed [WeightW-1:0] weight;
  status_e                   status;
  logic                      tared;
  logic                      calibrated;

  assign s_axis_tready = idle;
  assign item          = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  lcw_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item),
    .flags_i (flags),
    .op_o    (op),
    .idle_o  (idle)
  );

  lcw_dp #(
    .WEIGH_WINDOW (WEIGH_WINDOW),
    .TARE_WINDOW  (TARE_WINDOW)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .item_i         (item),
    .sample_i       ($signed(s_axis_tdata)),
    .mode_i         (s_axis_tuser),
    .cfg_we_i       (cfg_valid_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_divisor_o  (div_divisor),
    .div_busy_i     (div_busy),
    .div_quot_i     (div_quot),
    .flags_o        (flags),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .weight_o       (weight),
    .status_o       (status),
    .tared_o        (tared),
    .calibrated_o   (calibrated)
  );

  lcw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  assign m_axis_tdata = {6'h0, calibrated, tared, weight};
  assign m_axis_tuser = status;

endmodule

`default_nettype wire

[tb/scale_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scale_monitor
// Watches the sample, result and register channels of the load-cell scale.
// Keeps its own copy of the filter, window, tare and scale state, predicts the
// result of every completed window and checks the result stream in order.
// ----------------------------------------------------------------------------
module scale_monitor #(
  parameter int WEIGH_WINDOW = 8,
  parameter int TARE_WINDOW  = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [23:0]                  s_axis_tdata,   // [23:0] sample
  input  logic [1:0]                   s_axis_tuser,   // [1:0] mode
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [39:0]                  m_axis_tdata,   // [31:0] weight, [32] tared,
                                                       // [33] calibrated, zero pad
  input  logic [1:0]                   m_axis_tuser,   // [1:0] status
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [lcw_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [lcw_pkg::CfgDataW-1:0] cfg_data_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import lcw_pkg::*;

  typedef struct packed {
    logic signed [31:0] weight;
    status_e            status;
    logic               tared;
    logic               calibrated;
  } window_result_t;

  localparam longint GramScale = 64'sd16777216;  // 2^24
  localparam longint WeightMax = 64'sd2147483647;

  window_result_t window_results[$];

  logic        filt_on;
  logic [15:0] alpha_q;
  logic [23:0] ref_weight_q;
  logic [23:0] known_weight_q;
  longint      filt_acc;
  longint      win_sum;
  int          win_count;
  mode_e       win_mode;
  longint      tare_offset;
  longint      tare_ref;
  longint      counts_per_gram;
  logic        have_tare;
  logic        have_scale;
  int          fails = 0;

  task automatic write_register(input logic [CfgAddrW-1:0] idx,
                                input logic [CfgDataW-1:0] val);
    case (idx)
      REG_FILTER_EN: begin
        filt_on  = val[0];
        filt_acc = 0;
      end
      REG_ALPHA: alpha_q        = val[15:0];
      REG_REF:   ref_weight_q   = val[23:0];
      REG_KNOWN: known_weight_q = val[23:0];
      default: ;
    endcase
  endtask

  // Accumulate one item; on the last item of a window queue its result.
  task automatic take_sample(input logic signed [23:0] smp, input logic [1:0] md);
    longint         x;
    longint         diff;
    longint         term;
    longint         avg;
    longint         net;
    longint         w;
    int             len;
    window_result_t res;
    x = longint'(smp);
    if (win_count == 0) win_mode = (md == 2'd3) ? MODE_WEIGH : mode_e'(md);
    if (filt_on) begin
      diff     = x * 65536 - filt_acc;
      filt_acc = filt_acc + (longint'(alpha_q) * diff) / 65536;
      term     = filt_acc / 65536;
    end else begin
      term = x;
    end
    win_sum   = win_sum + term;
    win_count = win_count + 1;
    len = (win_mode == MODE_WEIGH) ? WEIGH_WINDOW : TARE_WINDOW;
    if (win_count < len) return;

    avg       = win_sum / len;
    win_sum   = 0;
    win_count = 0;
    w         = 0;
    case (win_mode)
      MODE_TARE: begin
        tare_offset = avg;
        tare_ref    = longint'(ref_weight_q);
        have_tare   = 1'b1;
        w           = avg;
        res.status  = ST_TARE;
      end
      MODE_CAL: begin
        net = avg - tare_offset;
        if (have_tare && net > 0 && longint'(known_weight_q) > tare_ref) begin
          counts_per_gram = (net * GramScale) / (longint'(known_weight_q) - tare_ref);
          have_scale      = 1'b1;
          res.status      = ST_CAL;
        end else begin
          res.status = ST_REJECT;
        end
      end
      default: begin
        if (!have_tare) begin
          w = avg;
        end else begin
          net = avg - tare_offset;
          w   = (net * GramScale) / counts_per_gram + tare_ref;
          if (w < 0) w = 0;
          if (w > WeightMax) w = WeightMax;
        end
        res.status = ST_WEIGHT;
      end
    endcase
    res.weight     = w[31:0];
    res.tared      = have_tare;
    res.calibrated = have_scale;
    window_results.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    window_result_t want;
    if (!rst_ni) begin
      filt_on         = 1'b0;
      alpha_q         = '0;
      ref_weight_q    = '0;
      known_weight_q  = '0;
      filt_acc        = 0;
      win_sum         = 0;
      win_count       = 0;
      win_mode        = MODE_WEIGH;
      tare_offset     = 0;
      tare_ref        = 0;
      counts_per_gram = longint'(CpgReset);
      have_tare       = 1'b0;
      have_scale      = 1'b0;
      window_results.delete();
    end else begin
      // check the outgoing item before queueing anything new at this edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (window_results.size() == 0) begin
          fails++;
          $error("unexpected result: weight %0d, status %0d",
                 $signed(m_axis_tdata[31:0]), m_axis_tuser);
        end else begin
          want = window_results.pop_front();
          if (m_axis_tdata[31:0] !== want.weight) begin
            fails++;
            $error("weight: expected %0d, actual %0d", want.weight,
                   $signed(m_axis_tdata[31:0]));
          end
          if (m_axis_tuser !== want.status) begin
            fails++;
            $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
          end
          if (m_axis_tdata[32] !== want.tared) begin
            fails++;
            $error("tared: expected %0d, actual %0d", want.tared, m_axis_tdata[32]);
          end
          if (m_axis_tdata[33] !== want.calibrated) begin
            fails++;
            $error("calibrated: expected %0d, actual %0d", want.calibrated,
                   m_axis_tdata[33]);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) write_register(cfg_addr_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) take_sample(s_axis_tdata, s_axis_tuser);
    end
    fail_count_o <= fails;
    pending_o    <= window_results.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives raw samples, mostly in whole windows of weigh, tare and calibrate, through
// the load-cell scale under random idling on both streams, rewrites the registers
// between phases and takes the verdict from the scale monitor.
// ----------------------------------------------------------------------------
module testbench;
  import lcw_pkg::*;

  localparam int WeighWindow  = 8;
  localparam int TareWindow   = 64;
  localparam int RandomItems  = 1000;
  // the limit covers the slowest run: gaps, windows with two divides, the long hold
  localparam int CycleLimit   = 1000000;
  localparam int SettleCycles = 16;
  localparam int DrainCycles  = 250;
  localparam int HoldCycles   = 3000;
  localparam int HoldAtResult = 30;
  localparam int SampleMax    = 8388607;
  localparam int SampleMin    = -8388608;
  localparam logic [1:0] ModeUnused = 2'd3;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata  = '0;   // [23:0] sample
  logic [1:0]          s_axis_tuser  = '0;   // [1:0] mode
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [39:0]         m_axis_tdata;         // [31:0] weight, [32] tared,
                                             // [33] calibrated, zero pad
  logic [1:0]          m_axis_tuser;         // [1:0] status
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  logic [CfgAddrW-1:0] cfg_addr      = '0;
  logic [CfgDataW-1:0] cfg_data      = '0;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int items_sent  = 0;
  int win_left    = 0;
  bit send_calm   = 1'b0;
  bit sink_calm   = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  load_cell_tare_calibrate_weigh #(
    .WEIGH_WINDOW(WeighWindow),
    .TARE_WINDOW (TareWindow)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_addr_i   (cfg_addr),
    .cfg_data_i   (cfg_data)
  );

  scale_monitor #(
    .WEIGH_WINDOW(WeighWindow),
    .TARE_WINDOW (TareWindow)
  ) u_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_addr_i   (cfg_addr),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Sample around a level, clipped to the converter range.
  function automatic logic [23:0] near(input int level, input int spread);
    longint v;
    v = longint'(level) + longint'($urandom_range(0, 2 * spread)) - spread;
    if (v > SampleMax) v = SampleMax;
    if (v < SampleMin) v = SampleMin;
    return v[23:0];
  endfunction

  task automatic send_sample(input logic [23:0] smp, input logic [1:0] md);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 11);
    repeat (gap) @(negedge clk_i) s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= md;
    do @(posedge clk_i); while (!s_axis_tready);
    // follow the window boundaries so that the mode lands on a first item
    if (win_left == 0)
      win_left = (md == MODE_TARE || md == MODE_CAL) ? TareWindow : WeighWindow;
    win_left--;
    items_sent++;
  endtask

  // Finish any open window, then send one whole window of the given mode.
  task automatic send_window(input logic [1:0] md, input int level, input int spread);
    int len;
    while (win_left != 0) send_sample(near(level, spread), 2'($urandom_range(0, 3)));
    len = (md == MODE_TARE || md == MODE_CAL) ? TareWindow : WeighWindow;
    send_sample(near(level, spread), md);
    // later modes in a window must be ignored
    for (int i = 1; i < len; i++)
      send_sample(near(level, spread), 2'($urandom_range(0, 3)));
  endtask

  task automatic settle();
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Bits outside the register field carry random values.
  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [31:0] val,
                           input logic [31:0] keep);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= ($urandom() & ~keep) | (val & keep);
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i) cfg_valid <= 1'b0;
  endtask

  task automatic pick_config();
    logic [23:0] refw;
    logic [23:0] knw;
    logic [15:0] alpha;
    case ($urandom_range(0, 3))
      0:       refw = '0;
      1:       refw = 24'hFFFFFF;
      default: refw = 24'($urandom_range(0, 1 << 20));
    endcase
    case ($urandom_range(0, 4))
      0:       knw = '0;
      1:       knw = 24'hFFFFFF;
      2:       knw = 24'($urandom());
      default: knw = refw + 24'($urandom_range(1, 1 << 20));
    endcase
    case ($urandom_range(0, 3))
      0:       alpha = '0;
      1:       alpha = 16'hFFFF;
      default: alpha = 16'($urandom());
    endcase
    if ($urandom_range(0, 1)) write_reg(REG_FILTER_EN, 32'($urandom_range(0, 1)), 32'h1);
    if ($urandom_range(0, 3) != 0) write_reg(REG_ALPHA, alpha, 32'hFFFF);
    write_reg(REG_REF, refw, 32'hFFFFFF);
    write_reg(REG_KNOWN, knw, 32'hFFFFFF);
    if ($urandom_range(0, 5) == 0) write_reg(8'($urandom_range(4, 255)), $urandom(), '0);
  endtask

  // One phase: tare at an empty level, calibrate on a load, weigh in between.
  task automatic run_phase();
    int empty;
    int load;
    int spread;
    int stop_at;
    int pick;
    logic [1:0] md;
    empty   = int'($urandom_range(0, 8388607)) - 4194304;
    load    = $urandom_range(1, 2000000);
    spread  = ($urandom_range(0, 3) == 0) ? 0 : (1 << $urandom_range(0, 23)) - 1;
    stop_at = items_sent + $urandom_range(80, 200);
    send_calm = ($urandom_range(0, 3) == 0);
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 19);
      md   = ($urandom_range(0, 7) == 0) ? ModeUnused : MODE_WEIGH;
      if (pick < 10)
        send_window(md, empty + int'($urandom_range(0, 2 * load)) - load / 2, spread);
      else if (pick < 13)
        send_window(MODE_TARE, empty, spread);
      else if (pick < 15)
        send_window(MODE_CAL, empty + load, spread);
      else if (pick == 15)
        send_window(MODE_CAL, empty - load, spread);
      else if (pick < 18)
        repeat ($urandom_range(1, 12)) send_sample(24'($urandom()), 2'($urandom_range(0, 3)));
      else
        send_window(md, 0, SampleMax);
    end
  endtask

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : result_sink
    int gap;
    int taken;
    taken = 0;
    wait (rst_ni);
    forever begin
      // hold off long enough for the result register and sequencer to back up
      if (taken == HoldAtResult) repeat (HoldCycles) @(negedge clk_i) m_axis_tready <= 1'b0;
      if (taken % 40 == 0) sink_calm = ($urandom_range(0, 2) == 0);
      gap = sink_calm ? 0 : $urandom_range(0, 11);
      repeat (gap) @(negedge clk_i) m_axis_tready <= 1'b0;
      @(negedge clk_i) m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
    end
  end

  initial begin : stimulus
    int random_end;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // calibrating before any tare still runs the window, then rejects
    send_window(MODE_CAL, 1000, 0);
    send_window(MODE_WEIGH, SampleMax, 0);
    send_window(ModeUnused, SampleMin, 0);
    settle();
    write_reg(REG_FILTER_EN, 32'd0, 32'h1);
    write_reg(REG_ALPHA, 32'hFFFF, 32'hFFFF);
    write_reg(REG_REF, 32'hFFFFFF, 32'hFFFFFF);
    write_reg(REG_KNOWN, 32'd0, 32'hFFFFFF);
    write_reg(8'hC5, $urandom(), '0);
    send_window(MODE_TARE, SampleMin, 0);
    send_window(MODE_WEIGH, SampleMax, 0);   // saturates high
    send_window(MODE_WEIGH, SampleMin, 0);   // zero net leaves the reference
    send_window(MODE_CAL, 0, 0);             // known weight not above reference
    settle();
    write_reg(REG_REF, 32'd0, 32'hFFFFFF);
    write_reg(REG_KNOWN, 32'hFFFFFF, 32'hFFFFFF);
    send_window(MODE_TARE, 0, 0);
    send_window(MODE_WEIGH, SampleMin, 0);   // below tare, clamps to zero
    send_window(MODE_CAL, SampleMin, 0);     // negative net, rejected
    send_window(MODE_CAL, SampleMax, 0);
    send_window(MODE_WEIGH, 1 << 22, 4096);
    settle();
    write_reg(REG_FILTER_EN, 32'd1, 32'h1);
    send_window(MODE_WEIGH, SampleMax, 0);
    settle();
    // a new coefficient alone keeps the filter state
    write_reg(REG_ALPHA, 32'h0100, 32'hFFFF);
    send_window(MODE_WEIGH, SampleMin, 0);
    settle();
    write_reg(REG_ALPHA, 32'd0, 32'hFFFF);
    send_window(MODE_WEIGH, 12345, 0);
    settle();

    random_end = items_sent + RandomItems;
    while (items_sent < random_end) begin
      pick_config();
      run_phase();
      settle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
